[sv/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define XIBE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define XIBE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/xibe_pkg.sv]
package xibe_pkg;

  localparam int MAX_BYTES = 8;

  typedef enum logic [4:0] {
    ACT_PUSH_IMM  = 5'd0,
    ACT_PUSH_REG  = 5'd1,
    ACT_POP       = 5'd2,
    ACT_MOV_RR    = 5'd3,
    ACT_MOV_RI    = 5'd4,
    ACT_LOAD      = 5'd5,
    ACT_STORE     = 5'd6,
    ACT_LOAD_RIP  = 5'd7,
    ACT_LOAD_DISP = 5'd8,
    ACT_ADD_RR    = 5'd9,
    ACT_SUB_RR    = 5'd10,
    ACT_CMP_RR    = 5'd11,
    ACT_ADD_RI    = 5'd12,
    ACT_SUB_RI    = 5'd13,
    ACT_INC       = 5'd14,
    ACT_DEC       = 5'd15,
    ACT_IMUL      = 5'd16,
    ACT_IDIV      = 5'd17,
    ACT_CALL      = 5'd18,
    ACT_JUMP      = 5'd19,
    ACT_NOP       = 5'd20,
    ACT_RET       = 5'd21,
    ACT_SYSCALL   = 5'd22
  } action_t;

  localparam logic [3:0] COND_JMP = 4'd0;
  localparam logic [3:0] COND_MAX = 4'd10;

  localparam logic [7:0] OP_REX_W     = 8'h48;
  localparam logic [7:0] OP_REX_B     = 8'h41;
  localparam logic [7:0] OP_PUSH_I8   = 8'h6a;
  localparam logic [7:0] OP_PUSH_I32  = 8'h68;
  localparam logic [7:0] OP_MOV_ST    = 8'h89;
  localparam logic [7:0] OP_MOV_LD    = 8'h8b;
  localparam logic [7:0] OP_MOV_IMM   = 8'hc7;
  localparam logic [7:0] OP_ADD       = 8'h01;
  localparam logic [7:0] OP_SUB       = 8'h29;
  localparam logic [7:0] OP_CMP       = 8'h39;
  localparam logic [7:0] OP_ALU_I8    = 8'h83;
  localparam logic [7:0] OP_ALU_I32   = 8'h81;
  localparam logic [7:0] OP_GRP5      = 8'hff;
  localparam logic [7:0] OP_GRP3      = 8'hf7;
  localparam logic [7:0] OP_CALL      = 8'he8;
  localparam logic [7:0] OP_JMP_NEAR  = 8'he9;
  localparam logic [7:0] OP_ESC       = 8'h0f;
  localparam logic [7:0] OP_SYSCALL   = 8'h05;
  localparam logic [7:0] OP_NOP       = 8'h90;
  localparam logic [7:0] OP_RET       = 8'hc3;
  localparam logic [7:0] SIB_NO_INDEX = 8'h24;
  localparam logic [7:0] JCC_NEAR_ADD = 8'h10;

  localparam logic [2:0] EXT_ADD  = 3'd0;
  localparam logic [2:0] EXT_INC  = 3'd0;
  localparam logic [2:0] EXT_DEC  = 3'd1;
  localparam logic [2:0] EXT_SUB  = 3'd5;
  localparam logic [2:0] EXT_IMUL = 3'd5;
  localparam logic [2:0] EXT_IDIV = 3'd7;

  localparam logic [2:0] RM_SIB  = 3'b100;
  localparam logic [2:0] RM_BP   = 3'b101;

  localparam logic [1:0] MOD_IND   = 2'd0;
  localparam logic [1:0] MOD_DISP8 = 2'd1;
  localparam logic [1:0] MOD_DISP32 = 2'd2;
  localparam logic [1:0] MOD_REG   = 2'd3;

  typedef struct packed {
    logic [4:0]         action;
    logic [3:0]         dst_reg;
    logic [3:0]         src_reg;
    logic signed [31:0] immediate;
    logic [3:0]         condition;
  } in_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_byte;
  } out_t;

  function automatic logic [7:0] short_op(input logic [3:0] c);
    logic [7:0] r;
    case (c)
      4'd1:    r = 8'h77;
      4'd2:    r = 8'h73;
      4'd3:    r = 8'h72;
      4'd4:    r = 8'h76;
      4'd5:    r = 8'h74;
      4'd6:    r = 8'h75;
      4'd7:    r = 8'h7c;
      4'd8:    r = 8'h7e;
      4'd9:    r = 8'h7f;
      4'd10:   r = 8'h7d;
      default: r = 8'heb;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] rex(input logic [3:0] regf, input logic [3:0] rmf);
    return OP_REX_W | {5'd0, regf[3], 1'b0, rmf[3]};
  endfunction

endpackage

[sv/xibe_stream_if.sv]
interface xibe_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/x86_64_instruction_byte_encoder.sv]
// x86-64 instruction byte encoder. Each request on in_chan describes one
// instruction; out_chan returns its machine code one byte per cycle while
// out_chan.ready is high, in memory order, last_byte marking the final byte
// (1 to 8 bytes per instruction, unknown actions give none and are dropped).
// A request goes through three register stages (capture, operand sizing and
// branch offset add, byte assembly) into an output shift register. A new
// request is taken every cycle while stages are free; sustained throughput is
// set by the single-byte output shifter, which sends all bytes of one
// instruction before it loads the next.
`include "assert_macros.svh"

module x86_64_instruction_byte_encoder (
  input  logic clk,
  input  logic rst_n,
  xibe_stream_if.sink   in_chan,
  xibe_stream_if.source out_chan
);

  typedef struct packed {
    logic [4:0]  action;
    logic [3:0]  dst;
    logic [3:0]  src;
    logic [31:0] imm;
    logic [3:0]  jc;
    logic        fit8;
    logic        izero;
    logic        jshort;
    logic [31:0] ofs;
  } cls_t;

  typedef struct packed {
    logic [xibe_pkg::MAX_BYTES-1:0][7:0] byt;
    logic [3:0]                          len;
  } enc_t;

  xibe_pkg::in_t a_r;
  logic          a_vld_r;
  cls_t          b_r, b_nxt;
  logic          b_vld_r;
  enc_t          c_r, c_nxt;
  logic          c_vld_r;
  logic [xibe_pkg::MAX_BYTES-1:0][7:0] buf_r;
  logic [3:0]    cnt_r;

  logic out_fire, ser_free, ser_ld, c_take, b_take, a_take;

  assign out_fire = out_chan.valid && out_chan.ready;
  assign ser_free = (cnt_r == 4'd0) || (out_fire && cnt_r == 4'd1);
  assign ser_ld   = c_vld_r && (c_r.len != 4'd0) && ser_free;
  assign c_take   = !c_vld_r || (c_r.len == 4'd0) || ser_free;
  assign b_take   = !b_vld_r || c_take;
  assign a_take   = !a_vld_r || b_take;

  assign in_chan.ready             = a_take;
  assign out_chan.valid            = cnt_r != 4'd0;
  assign out_chan.data.code_byte   = buf_r[0];
  assign out_chan.data.last_byte   = cnt_r == 4'd1;

  // sizing and offset
  always_comb begin
    logic signed [31:0] s;
    logic [31:0]        sub;
    s = a_r.immediate;
    b_nxt.action = a_r.action;
    b_nxt.dst    = a_r.dst_reg;
    b_nxt.src    = a_r.src_reg;
    b_nxt.imm    = a_r.immediate;
    b_nxt.jc     = (a_r.condition > xibe_pkg::COND_MAX) ? xibe_pkg::COND_JMP : a_r.condition;
    b_nxt.fit8   = (s >= -32'sd128) && (s <= 32'sd127);
    b_nxt.izero  = a_r.immediate == 32'd0;
    b_nxt.jshort = (s > -32'sd100) && (s < 32'sd100);
    if (a_r.action == xibe_pkg::ACT_CALL) begin
      sub = 32'd5;
    end else if (b_nxt.jshort) begin
      sub = 32'd2;
    end else if (b_nxt.jc == xibe_pkg::COND_JMP) begin
      sub = 32'd5;
    end else begin
      sub = 32'd6;
    end
    b_nxt.ofs = a_r.immediate - sub;
  end

  // byte assembly
  always_comb begin
    logic [3:0]  n;
    logic        mem_en, tail8, tail32;
    logic [31:0] tv, dispv;
    logic [3:0]  regf, base;
    logic [1:0]  mmod;
    logic [7:0]  op;
    logic [2:0]  ext;
    c_nxt.byt = '0;
    n = 4'd0;
    mem_en = 1'b0;
    tail8 = 1'b0;
    tail32 = 1'b0;
    tv = b_r.imm;
    dispv = 32'd0;
    regf = b_r.dst;
    base = b_r.src;
    mmod = xibe_pkg::MOD_IND;
    op = xibe_pkg::OP_NOP;
    ext = 3'd0;
    case (b_r.action)
      xibe_pkg::ACT_PUSH_IMM: begin
        c_nxt.byt[n[2:0]] = b_r.fit8 ? xibe_pkg::OP_PUSH_I8 : xibe_pkg::OP_PUSH_I32;
        n = n + 4'd1;
        tail8 = b_r.fit8;
        tail32 = !b_r.fit8;
      end
      xibe_pkg::ACT_PUSH_REG, xibe_pkg::ACT_POP: begin
        if (b_r.dst[3]) begin
          c_nxt.byt[n[2:0]] = xibe_pkg::OP_REX_B;
          n = n + 4'd1;
        end
        c_nxt.byt[n[2:0]] = {4'b0101, b_r.action == xibe_pkg::ACT_POP, b_r.dst[2:0]};
        n = n + 4'd1;
      end
      xibe_pkg::ACT_MOV_RR, xibe_pkg::ACT_ADD_RR, xibe_pkg::ACT_SUB_RR,
      xibe_pkg::ACT_CMP_RR: begin
        case (b_r.action)
          xibe_pkg::ACT_ADD_RR: op = xibe_pkg::OP_ADD;
          xibe_pkg::ACT_SUB_RR: op = xibe_pkg::OP_SUB;
          xibe_pkg::ACT_CMP_RR: op = xibe_pkg::OP_CMP;
          default:              op = xibe_pkg::OP_MOV_ST;
        endcase
        c_nxt.byt[n[2:0]] = xibe_pkg::rex(b_r.src, b_r.dst);
        n = n + 4'd1;
        c_nxt.byt[n[2:0]] = op;
        n = n + 4'd1;
        c_nxt.byt[n[2:0]] = {xibe_pkg::MOD_REG, b_r.src[2:0], b_r.dst[2:0]};
        n = n + 4'd1;
      end
      xibe_pkg::ACT_MOV_RI, xibe_pkg::ACT_ADD_RI, xibe_pkg::ACT_SUB_RI,
      xibe_pkg::ACT_INC, xibe_pkg::ACT_DEC, xibe_pkg::ACT_IMUL,
      xibe_pkg::ACT_IDIV: begin
        case (b_r.action)
          xibe_pkg::ACT_MOV_RI: begin
            op = xibe_pkg::OP_MOV_IMM; ext = 3'd0; tail32 = 1'b1;
          end
          xibe_pkg::ACT_ADD_RI: begin
            op = b_r.fit8 ? xibe_pkg::OP_ALU_I8 : xibe_pkg::OP_ALU_I32;
            ext = xibe_pkg::EXT_ADD; tail8 = b_r.fit8; tail32 = !b_r.fit8;
          end
          xibe_pkg::ACT_SUB_RI: begin
            op = b_r.fit8 ? xibe_pkg::OP_ALU_I8 : xibe_pkg::OP_ALU_I32;
            ext = xibe_pkg::EXT_SUB; tail8 = b_r.fit8; tail32 = !b_r.fit8;
          end
          xibe_pkg::ACT_INC: begin
            op = xibe_pkg::OP_GRP5; ext = xibe_pkg::EXT_INC;
          end
          xibe_pkg::ACT_DEC: begin
            op = xibe_pkg::OP_GRP5; ext = xibe_pkg::EXT_DEC;
          end
          xibe_pkg::ACT_IMUL: begin
            op = xibe_pkg::OP_GRP3; ext = xibe_pkg::EXT_IMUL;
          end
          default: begin
            op = xibe_pkg::OP_GRP3; ext = xibe_pkg::EXT_IDIV;
          end
        endcase
        c_nxt.byt[n[2:0]] = xibe_pkg::rex(4'd0, b_r.dst);
        n = n + 4'd1;
        c_nxt.byt[n[2:0]] = op;
        n = n + 4'd1;
        c_nxt.byt[n[2:0]] = {xibe_pkg::MOD_REG, ext, b_r.dst[2:0]};
        n = n + 4'd1;
      end
      xibe_pkg::ACT_LOAD, xibe_pkg::ACT_LOAD_DISP: begin
        c_nxt.byt[n[2:0]] = xibe_pkg::rex(b_r.dst, b_r.src);
        n = n + 4'd1;
        c_nxt.byt[n[2:0]] = xibe_pkg::OP_MOV_LD;
        n = n + 4'd1;
        mem_en = 1'b1;
        if (b_r.action == xibe_pkg::ACT_LOAD) begin
          mmod = (b_r.src[2:0] == xibe_pkg::RM_BP) ? xibe_pkg::MOD_DISP8 : xibe_pkg::MOD_IND;
        end else begin
          dispv = b_r.imm;
          if (b_r.izero && b_r.src[2:0] != xibe_pkg::RM_BP) begin
            mmod = xibe_pkg::MOD_IND;
          end else if (b_r.fit8) begin
            mmod = xibe_pkg::MOD_DISP8;
          end else begin
            mmod = xibe_pkg::MOD_DISP32;
          end
        end
      end
      xibe_pkg::ACT_STORE: begin
        c_nxt.byt[n[2:0]] = xibe_pkg::rex(b_r.src, b_r.dst);
        n = n + 4'd1;
        c_nxt.byt[n[2:0]] = xibe_pkg::OP_MOV_ST;
        n = n + 4'd1;
        mem_en = 1'b1;
        regf = b_r.src;
        base = b_r.dst;
        mmod = (b_r.dst[2:0] == xibe_pkg::RM_BP) ? xibe_pkg::MOD_DISP8 : xibe_pkg::MOD_IND;
      end
      xibe_pkg::ACT_LOAD_RIP: begin
        c_nxt.byt[n[2:0]] = xibe_pkg::rex(b_r.dst, 4'd0);
        n = n + 4'd1;
        c_nxt.byt[n[2:0]] = xibe_pkg::OP_MOV_LD;
        n = n + 4'd1;
        c_nxt.byt[n[2:0]] = {xibe_pkg::MOD_IND, b_r.dst[2:0], xibe_pkg::RM_BP};
        n = n + 4'd1;
        tail32 = 1'b1;
      end
      xibe_pkg::ACT_CALL: begin
        c_nxt.byt[n[2:0]] = xibe_pkg::OP_CALL;
        n = n + 4'd1;
        tv = b_r.ofs;
        tail32 = 1'b1;
      end
      xibe_pkg::ACT_JUMP: begin
        tv = b_r.ofs;
        if (b_r.jshort) begin
          c_nxt.byt[n[2:0]] = xibe_pkg::short_op(b_r.jc);
          n = n + 4'd1;
          tail8 = 1'b1;
        end else if (b_r.jc == xibe_pkg::COND_JMP) begin
          c_nxt.byt[n[2:0]] = xibe_pkg::OP_JMP_NEAR;
          n = n + 4'd1;
          tail32 = 1'b1;
        end else begin
          c_nxt.byt[n[2:0]] = xibe_pkg::OP_ESC;
          n = n + 4'd1;
          c_nxt.byt[n[2:0]] = xibe_pkg::short_op(b_r.jc) + xibe_pkg::JCC_NEAR_ADD;
          n = n + 4'd1;
          tail32 = 1'b1;
        end
      end
      xibe_pkg::ACT_NOP: begin
        c_nxt.byt[n[2:0]] = xibe_pkg::OP_NOP;
        n = n + 4'd1;
      end
      xibe_pkg::ACT_RET: begin
        c_nxt.byt[n[2:0]] = xibe_pkg::OP_RET;
        n = n + 4'd1;
      end
      xibe_pkg::ACT_SYSCALL: begin
        c_nxt.byt[n[2:0]] = xibe_pkg::OP_ESC;
        n = n + 4'd1;
        c_nxt.byt[n[2:0]] = xibe_pkg::OP_SYSCALL;
        n = n + 4'd1;
      end
      default: begin
      end
    endcase
    if (mem_en) begin
      c_nxt.byt[n[2:0]] = {mmod, regf[2:0], base[2:0]};
      n = n + 4'd1;
      if (base[2:0] == xibe_pkg::RM_SIB) begin
        c_nxt.byt[n[2:0]] = xibe_pkg::SIB_NO_INDEX;
        n = n + 4'd1;
      end
      tv = dispv;
      tail8 = mmod == xibe_pkg::MOD_DISP8;
      tail32 = mmod == xibe_pkg::MOD_DISP32;
    end
    if (tail8) begin
      c_nxt.byt[n[2:0]] = tv[7:0];
      n = n + 4'd1;
    end
    if (tail32) begin
      c_nxt.byt[n[2:0]] = tv[7:0];
      n = n + 4'd1;
      c_nxt.byt[n[2:0]] = tv[15:8];
      n = n + 4'd1;
      c_nxt.byt[n[2:0]] = tv[23:16];
      n = n + 4'd1;
      c_nxt.byt[n[2:0]] = tv[31:24];
      n = n + 4'd1;
    end
    c_nxt.len = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      cnt_r   <= 4'd0;
    end else begin
      if (a_take) begin
        a_vld_r <= in_chan.valid;
      end
      if (b_take) begin
        b_vld_r <= a_vld_r;
      end
      if (c_take) begin
        c_vld_r <= b_vld_r;
      end
      if (ser_ld) begin
        cnt_r <= c_r.len;
      end else if (out_fire) begin
        cnt_r <= cnt_r - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_take) begin
      a_r <= in_chan.data;
    end
    if (b_take) begin
      b_r <= b_nxt;
    end
    if (c_take) begin
      c_r <= c_nxt;
    end
    if (ser_ld) begin
      buf_r <= c_r.byt;
    end else if (out_fire) begin
      buf_r <= {8'h00, buf_r[xibe_pkg::MAX_BYTES-1:1]};
    end
  end

  `XIBE_ASSERT(a_len_range, clk, rst_n, ser_ld |-> c_r.len <= 4'd8, "instruction longer than 8 bytes")
  `XIBE_ASSERT(a_more_bytes, clk, rst_n, (out_fire && !out_chan.data.last_byte) |=> out_chan.valid, "request cut short before last byte")
  `XIBE_ASSERT(a_c_hold, clk, rst_n, (c_vld_r && !c_take) |=> (c_vld_r && $stable(c_r.len)), "stalled assembly stage changed")
  `XIBE_ASSERT_ALWAYS(a_rst_idle, clk, !rst_n |=> !out_chan.valid, "output valid after reset")

endmodule
